@@ src/owrs_pkg.sv @@
package owrs_pkg;

  localparam int unsigned ROM_BITS_DEF = 64;
  localparam int unsigned ROM_CODE_W   = 64;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned FAMILY_W     = 8;
  localparam int unsigned FAMILY_LIMIT = 9;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    FUNC_BEGIN  = 2'd0,
    FUNC_BIT    = 2'd1,
    FUNC_TARGET = 2'd2,
    FUNC_SKIP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_CMD     = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_FOUND   = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_SETUP   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0]          func;
    logic                new_search;
    logic                no_presence;
    logic                id_bit;
    logic                cmp_bit;
    logic [FAMILY_W-1:0] fam_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  write_bit;
    logic [ROM_CODE_W-1:0] rom_code;
    logic                  last_device;
    logic [CNT_W-1:0]      bit_index;
  } out_item_t;

  // Decoded event as it travels from the front end to the sequencer.
  typedef struct packed {
    func_e               op;
    logic                new_search;
    logic                no_presence;
    logic                both_high;
    logic                forced;
    logic                id_bit;
    logic [FAMILY_W-1:0] fam_byte;
  } cmd_t;

endpackage

@@ src/owrs_if.sv @@
interface owrs_in_if;
  logic               valid;
  logic               ready;
  owrs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface owrs_out_if;
  logic                valid;
  logic                ready;
  owrs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/owrs_front.sv @@
module owrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  owrs_in_if.sink        in_i,
  output logic           cmd_valid_o,
  output owrs_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);

  localparam int unsigned Depth = owrs_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  owrs_pkg::cmd_t  mem_q [Depth];
  owrs_pkg::cmd_t  cmd_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  always_comb begin
    cmd_in             = '0;
    cmd_in.new_search  = in_i.data.new_search;
    cmd_in.no_presence = in_i.data.no_presence;
    cmd_in.both_high   = in_i.data.id_bit & in_i.data.cmp_bit;
    cmd_in.forced      = in_i.data.id_bit ^ in_i.data.cmp_bit;
    cmd_in.id_bit      = in_i.data.id_bit;
    cmd_in.fam_byte    = in_i.data.fam_byte;
    cmd_in.op          = owrs_pkg::func_e'(in_i.data.func);
  end

  assign in_i.ready  = (count_q != CntW'(Depth));
  assign push        = in_i.valid & in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ src/owrs_back.sv @@
module owrs_back #(
  parameter int unsigned ROM_BITS = owrs_pkg::ROM_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  owrs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  owrs_out_if.source     out_o
);

  localparam int unsigned CntW = owrs_pkg::CNT_W;
  localparam int unsigned IdxW = $clog2(ROM_BITS);

  logic [ROM_BITS-1:0] rom_q, rom_d;
  logic [CntW-1:0]     ld_q, ld_d;
  logic                flag_q, flag_d;
  logic [CntW-1:0]     lfd_q, lfd_d;
  logic [CntW-1:0]     num_q, num_d;
  logic [CntW-1:0]     lz_q, lz_d;
  logic                srch_q, srch_d;
  logic                out_valid_q;
  owrs_pkg::out_item_t out_q, res_d;
  logic                pop;
  logic                dir;
  logic [IdxW-1:0]     idx;

  assign pop       = cmd_valid_i & (~out_valid_q | out_o.ready);
  assign cmd_pop_o = pop;
  assign idx       = IdxW'(num_q - 1'b1);

  always_comb begin
    rom_d  = rom_q;
    ld_d   = ld_q;
    flag_d = flag_q;
    lfd_d  = lfd_q;
    num_d  = num_q;
    lz_d   = lz_q;
    srch_d = srch_q;
    dir    = 1'b0;
    res_d  = '0;
    res_d.kind = owrs_pkg::KIND_IGNORED;

    unique case (cmd_i.op)
      owrs_pkg::FUNC_BEGIN: begin
        srch_d = 1'b0;
        if (cmd_i.new_search) begin
          ld_d   = '0;
          flag_d = 1'b0;
          lfd_d  = '0;
          rom_d  = '0;
        end
        if ((flag_q && !cmd_i.new_search) || cmd_i.no_presence) begin
          ld_d       = '0;
          flag_d     = 1'b0;
          lfd_d      = '0;
          res_d.kind = owrs_pkg::KIND_NONE;
        end else begin
          num_d      = CntW'(1);
          lz_d       = '0;
          srch_d     = 1'b1;
          res_d.kind = owrs_pkg::KIND_CMD;
        end
      end
      owrs_pkg::FUNC_TARGET: begin
        srch_d     = 1'b0;
        rom_d      = ROM_BITS'(cmd_i.fam_byte);
        ld_d       = CntW'(ROM_BITS);
        lfd_d      = '0;
        flag_d     = 1'b0;
        res_d.kind = owrs_pkg::KIND_SETUP;
      end
      owrs_pkg::FUNC_SKIP: begin
        srch_d = 1'b0;
        ld_d   = lfd_q;
        lfd_d  = '0;
        if (lfd_q == '0) begin
          flag_d = 1'b1;
        end
        res_d.kind = owrs_pkg::KIND_SETUP;
      end
      default: begin
        if (!srch_q) begin
          res_d.kind = owrs_pkg::KIND_IGNORED;
        end else if (cmd_i.both_high) begin
          srch_d     = 1'b0;
          ld_d       = '0;
          flag_d     = 1'b0;
          lfd_d      = '0;
          res_d.kind = owrs_pkg::KIND_NONE;
        end else begin
          if (cmd_i.forced) begin
            dir = cmd_i.id_bit;
          end else begin
            if (num_q < ld_q) begin
              dir = rom_q[idx];
            end else begin
              dir = (num_q == ld_q);
            end
            if (!dir) begin
              lz_d = num_q;
              if (num_q < CntW'(owrs_pkg::FAMILY_LIMIT)) begin
                lfd_d = num_q;
              end
            end
          end
          rom_d[idx]      = dir;
          res_d.write_bit = dir;
          res_d.bit_index = num_q;
          if (num_q < CntW'(ROM_BITS)) begin
            num_d      = num_q + 1'b1;
            res_d.kind = owrs_pkg::KIND_WRITE;
          end else begin
            srch_d = 1'b0;
            num_d  = CntW'(1);
            ld_d   = lz_d;
            if (lz_d == '0) begin
              flag_d = 1'b1;
            end
            if (rom_d[owrs_pkg::FAMILY_W-1:0] == '0) begin
              ld_d       = '0;
              flag_d     = 1'b0;
              lfd_d      = '0;
              res_d.kind = owrs_pkg::KIND_NONE;
            end else begin
              res_d.kind        = owrs_pkg::KIND_FOUND;
              res_d.last_device = flag_d;
            end
          end
        end
      end
    endcase
    res_d.rom_code = owrs_pkg::ROM_CODE_W'(rom_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q       <= '0;
      ld_q        <= '0;
      flag_q      <= 1'b0;
      lfd_q       <= '0;
      num_q       <= CntW'(1);
      lz_q        <= '0;
      srch_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        rom_q       <= rom_d;
        ld_q        <= ld_d;
        flag_q      <= flag_d;
        lfd_q       <= lfd_d;
        num_q       <= num_d;
        lz_q        <= lz_d;
        srch_q      <= srch_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

@@ src/onewire_rom_search_core.sv @@
// Channel  Direction  Payload
// in_i     sink       func, new_search, no_presence, id_bit, cmp_bit, fam_byte
// out_o    source     kind, write_bit, rom_code, last_device, bit_index
//
// One event can be taken in every cycle while in_i.ready is high.
// An event passes a two-entry queue and then the sequencer's result register, so its
// result is valid on out_o only after both of them have been written.
// Reset is asynchronous and active low; no clearing pass follows it.
// A stalled output holds the result register; the queue then fills and in_i.ready drops.
module onewire_rom_search_core #(
  parameter int unsigned ROM_BITS = owrs_pkg::ROM_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  owrs_in_if.sink     in_i,
  owrs_out_if.source  out_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  owrs_pkg::cmd_t cmd;

  owrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  owrs_back #(
    .ROM_BITS (ROM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule
